### sv/cmds_pkg.sv
// ----------------------------------------------------------------------------
// cmds_pkg
// Shared types, codes and constants for the clock multiplier/divider block.
// ----------------------------------------------------------------------------
package cmds_pkg;

    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 20;
    localparam int CNT_W      = 16;
    localparam int TEMPO_W    = 9;
    localparam int BPM_W      = 9;
    localparam int MULT_W     = 6;
    localparam int PPQN_W     = 5;
    localparam int CMD_W      = 2;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int PROD_W     = 37;
    localparam int DVD_W      = 36;
    localparam int DVS_W      = 20;
    localparam int OFF_W      = 34;

    localparam int unsigned TICKS_PER_MIN = 1000000;
    localparam logic [PERIOD_W-1:0] TICKS_PER_MIN_W = 20'd1000000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 20'd8333;
    localparam logic [TEMPO_W-1:0]  TEMPO_RESET     = 9'd120;
    localparam logic signed [MULT_W-1:0] MULT_MIN   = -6'sd31;
    localparam logic signed [MULT_W-1:0] MULT_MAX   = 6'sd24;
    localparam logic [PPQN_W-1:0]   PPQN_MAX        = 5'd24;
    localparam logic [OFF_W-1:0]    NUDGE_MIN       = 34'd4;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEMPO  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESYNC = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PPQN = 3'd4;
    localparam int NUM_MULT_REGS = 4;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_MUL = 2'd1;
    localparam logic [1:0] MODE_DIV = 2'd2;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH      = 5'd1;
    localparam logic [OP_W-1:0] OP_RESYNC_IN  = 5'd2;
    localparam logic [OP_W-1:0] OP_BPM_DIV    = 5'd3;
    localparam logic [OP_W-1:0] OP_BPM_WR     = 5'd4;
    localparam logic [OP_W-1:0] OP_CH_EVAL    = 5'd5;
    localparam logic [OP_W-1:0] OP_CH_MDIV    = 5'd6;
    localparam logic [OP_W-1:0] OP_CH_MFIN    = 5'd7;
    localparam logic [OP_W-1:0] OP_CH_DFIN    = 5'd8;
    localparam logic [OP_W-1:0] OP_CH_NEXT    = 5'd9;
    localparam logic [OP_W-1:0] OP_RESTART    = 5'd10;
    localparam logic [OP_W-1:0] OP_SYNC_MUL   = 5'd11;
    localparam logic [OP_W-1:0] OP_SYNC_PER   = 5'd12;
    localparam logic [OP_W-1:0] OP_SYNC_TEMPO = 5'd13;
    localparam logic [OP_W-1:0] OP_OFF        = 5'd14;
    localparam logic [OP_W-1:0] OP_NUDGE      = 5'd15;
    localparam logic [OP_W-1:0] OP_LOAD_OUT   = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             hard;
        logic [1:0]       mode;
        logic             passed;
        logic             last_ch;
        logic             sync_go;
        logic             sync_ok;
        logic             div_busy;
    } t_dp_status;

    function automatic logic signed [MULT_W-1:0] clamp_mult(input logic [MULT_W-1:0] raw);
        logic signed [MULT_W-1:0] v;
        v = $signed(raw);
        if (v < MULT_MIN) begin
            return MULT_MIN;
        end else if (v > MULT_MAX) begin
            return MULT_MAX;
        end
        return v;
    endfunction

    function automatic logic [PPQN_W-1:0] clamp_ppqn(input logic [PPQN_W-1:0] raw);
        return (raw > PPQN_MAX) ? PPQN_MAX : raw;
    endfunction

endpackage

### sv/cmds_div.sv
// ----------------------------------------------------------------------------
// cmds_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmds_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cmds_pkg::DVD_W-1:0] i_dividend,
    input  logic [cmds_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [cmds_pkg::DVD_W-1:0] o_quot,
    output logic [cmds_pkg::DVS_W-1:0] o_rem
);
    localparam int DVD_W = cmds_pkg::DVD_W;
    localparam int DVS_W = cmds_pkg::DVS_W;
    localparam int CW    = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

### sv/cmds_dp.sv
// ----------------------------------------------------------------------------
// cmds_dp
// Datapath: beat state, per-channel counts, configuration, shared divider.
// ----------------------------------------------------------------------------
module cmds_dp #(
    parameter int NUM_CLOCKS = 4,
    parameter int TEMPO_MIN  = 1,
    parameter int TEMPO_MAX  = 300
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cmds_pkg::t_ctrl_cmd             i_ctl,
    output cmds_pkg::t_dp_status            o_st,
    input  logic [cmds_pkg::CMD_W-1:0]      i_cmd,
    input  logic [cmds_pkg::TIME_W-1:0]     i_now,
    input  logic                            i_clocked,
    input  logic                            i_hard_reset,
    input  logic                            i_skip_first,
    input  logic [cmds_pkg::BPM_W-1:0]      i_bpm,
    input  logic                            i_cfg_we,
    input  logic [cmds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cmds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [cmds_pkg::MASK_W-1:0]     o_tock_mask,
    output logic                            o_beat_restart,
    output logic [cmds_pkg::PERIOD_W-1:0]   o_beat_period_out,
    output logic [cmds_pkg::TEMPO_W-1:0]    o_tempo_out,
    output logic                            o_beat_phase_out
);
    localparam int CH_W     = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
    localparam int TIME_W   = cmds_pkg::TIME_W;
    localparam int PERIOD_W = cmds_pkg::PERIOD_W;
    localparam int CNT_W    = cmds_pkg::CNT_W;
    localparam int TEMPO_W  = cmds_pkg::TEMPO_W;
    localparam int MULT_W   = cmds_pkg::MULT_W;
    localparam int PPQN_W   = cmds_pkg::PPQN_W;
    localparam int PROD_W   = cmds_pkg::PROD_W;
    localparam int DVD_W    = cmds_pkg::DVD_W;
    localparam int DVS_W    = cmds_pkg::DVS_W;
    localparam int OFF_W    = cmds_pkg::OFF_W;
    localparam int MASK_W   = cmds_pkg::MASK_W;
    localparam logic [PERIOD_W-1:0] TICKS_MIN = PERIOD_W'(1000000 / TEMPO_MAX);
    localparam logic [PERIOD_W-1:0] TICKS_MAX = PERIOD_W'(1000000 / TEMPO_MIN);
    localparam logic [10:0] T_MIN = 11'(TEMPO_MIN);
    localparam logic [10:0] T_MAX = 11'(TEMPO_MAX);
    localparam logic signed [OFF_W-1:0] OFF_ONE = OFF_W'(1);

    logic signed [MULT_W-1:0] r_mult [NUM_CLOCKS];
    logic [PPQN_W-1:0]        r_ppqn;
    logic [PERIOD_W-1:0]      r_period, n_period;
    logic [TIME_W-1:0]        r_start, n_start;
    logic [CNT_W-1:0]         r_count [NUM_CLOCKS];
    logic [CNT_W-1:0]         n_count [NUM_CLOCKS];
    logic [TIME_W-1:0]        r_last, n_last;
    logic [TEMPO_W-1:0]       r_tempo, n_tempo;
    logic                     r_phase, n_phase;
    logic [CH_W-1:0]          r_ch, n_ch;
    logic                     r_all_met, n_all_met;
    logic [MASK_W-1:0]        r_mask, n_mask;
    logic                     r_restart, n_restart;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic [PERIOD_W-1:0]      r_half, n_half;
    logic signed [OFF_W-1:0]  r_off, n_off;

    logic [cmds_pkg::CMD_W-1:0] r_cmd;
    logic [TIME_W-1:0]          r_now;
    logic                       r_clocked;
    logic                       r_hard;
    logic                       r_skip;
    logic [cmds_pkg::BPM_W-1:0] r_bpm;

    logic                     div_start;
    logic [DVD_W-1:0]         dvd;
    logic [DVS_W-1:0]         dvs;
    logic                     div_busy;
    logic [DVD_W-1:0]         quot;
    logic [DVS_W-1:0]         rem;

    logic signed [MULT_W-1:0] m;
    logic [MULT_W-1:0]        m_u;
    logic [CNT_W-1:0]         cnt, cnt_inc, cnt_m;
    logic [1:0]               mode;
    logic [MULT_W-1:0]        dvr;
    logic [TIME_W-1:0]        dmark, mmark, diff, d32;
    logic                     passed, tk_m, met_m, tk_d, tk;
    logic [TEMPO_W-1:0]       bpm_c;
    logic                     sync_go, sync_ok;
    logic [PERIOD_W-1:0]      p_new, half;
    logic signed [OFF_W-1:0]  soff, off_adj, mag, adj;
    logic                     nudge;
    logic                     resync, rs_skip;

    cmds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    always_comb begin
        m       = r_mult[r_ch];
        m_u     = $unsigned(m);
        cnt     = r_count[r_ch];
        cnt_inc = (cnt == {CNT_W{1'b1}}) ? cnt : cnt + 1'b1;
        if (m == '0) begin
            mode = cmds_pkg::MODE_OFF;
        end else if (m[MULT_W-1]) begin
            mode = cmds_pkg::MODE_DIV;
        end else begin
            mode = cmds_pkg::MODE_MUL;
        end
        dvr    = MULT_W'(1) - m_u;
        dmark  = r_start + ((cnt != '0) ? {{(TIME_W-PERIOD_W){1'b0}}, r_period} : '0);
        passed = r_now > dmark;
        mmark  = r_start + quot[TIME_W-1:0];
        tk_m   = r_now >= mmark;
        cnt_m  = tk_m ? cnt_inc : cnt;
        met_m  = cnt_m > {{(CNT_W-MULT_W){1'b0}}, m_u};
        tk_d   = rem == DVS_W'(1);

        if ({2'b0, r_bpm} < T_MIN) begin
            bpm_c = TEMPO_W'(T_MIN);
        end else if ({2'b0, r_bpm} > T_MAX) begin
            bpm_c = TEMPO_W'(T_MAX);
        end else begin
            bpm_c = r_bpm;
        end

        diff    = r_now - r_last;
        sync_go = r_clocked && (r_last != '0) && (r_ppqn != '0);
        sync_ok = (r_prod != '0) && (r_prod <= PROD_W'(TICKS_MAX));
        p_new   = (r_prod[PERIOD_W-1:0] < TICKS_MIN) ? TICKS_MIN : r_prod[PERIOD_W-1:0];

        d32     = r_now - r_start;
        soff    = $signed({{(OFF_W-TIME_W){d32[TIME_W-1]}}, d32});
        half    = {1'b0, quot[PERIOD_W-1:1]};
        off_adj = (soff > $signed({{(OFF_W-PERIOD_W){1'b0}}, half}))
                ? soff - $signed({{(OFF_W-PERIOD_W){1'b0}}, r_period}) : soff;
        mag     = r_off[OFF_W-1] ? -r_off : r_off;
        nudge   = (mag < $signed({{(OFF_W-PERIOD_W){1'b0}}, r_half}))
                && (mag > $signed(cmds_pkg::NUDGE_MIN));
        adj     = r_off[OFF_W-1] ? r_off + OFF_ONE : r_off - OFF_ONE;
    end

    always_comb begin
        n_period  = r_period;
        n_start   = r_start;
        n_count   = r_count;
        n_last    = r_last;
        n_tempo   = r_tempo;
        n_phase   = r_phase;
        n_ch      = r_ch;
        n_all_met = r_all_met;
        n_mask    = r_mask;
        n_restart = r_restart;
        n_prod    = r_prod;
        n_half    = r_half;
        n_off     = r_off;
        div_start = 1'b0;
        dvd       = '0;
        dvs       = '0;
        resync    = 1'b0;
        rs_skip   = 1'b0;
        tk        = 1'b0;
        unique case (i_ctl.op)
            cmds_pkg::OP_NONE: begin
            end
            cmds_pkg::OP_LATCH: begin
                n_ch      = '0;
                n_all_met = 1'b1;
                n_mask    = '0;
                n_restart = 1'b0;
            end
            cmds_pkg::OP_RESYNC_IN: begin
                resync  = 1'b1;
                rs_skip = (r_cmd == cmds_pkg::CMD_RESYNC) && r_skip;
            end
            cmds_pkg::OP_BPM_DIV: begin
                div_start = 1'b1;
                dvd       = DVD_W'(cmds_pkg::TICKS_PER_MIN_W);
                dvs       = DVS_W'(bpm_c);
            end
            cmds_pkg::OP_BPM_WR: begin
                n_period = quot[PERIOD_W-1:0];
                n_tempo  = bpm_c;
            end
            cmds_pkg::OP_CH_EVAL: begin
                if (mode == cmds_pkg::MODE_MUL) begin
                    n_prod = PROD_W'(DVD_W'(cnt) * DVD_W'(r_period));
                end else if (mode == cmds_pkg::MODE_DIV) begin
                    if (passed) begin
                        n_count[r_ch] = cnt_inc;
                        div_start     = 1'b1;
                        dvd           = DVD_W'(cnt_inc);
                        dvs           = DVS_W'(dvr);
                    end else begin
                        n_all_met = 1'b0;
                    end
                end
            end
            cmds_pkg::OP_CH_MDIV: begin
                div_start = 1'b1;
                dvd       = r_prod[DVD_W-1:0];
                dvs       = DVS_W'(m_u);
            end
            cmds_pkg::OP_CH_MFIN: begin
                n_count[r_ch] = cnt_m;
                n_all_met     = r_all_met && met_m;
                tk            = tk_m;
            end
            cmds_pkg::OP_CH_DFIN: begin
                if (tk_d) begin
                    n_count[r_ch] = CNT_W'(1);
                end
                tk = tk_d;
            end
            cmds_pkg::OP_CH_NEXT: begin
                n_ch = r_ch + 1'b1;
            end
            cmds_pkg::OP_RESTART: begin
                if (r_all_met) begin
                    resync    = 1'b1;
                    rs_skip   = 1'b1;
                    n_restart = 1'b1;
                end
            end
            cmds_pkg::OP_SYNC_MUL: begin
                n_prod = PROD_W'(r_ppqn) * PROD_W'(diff);
            end
            cmds_pkg::OP_SYNC_PER: begin
                n_period  = p_new;
                div_start = 1'b1;
                dvd       = DVD_W'(cmds_pkg::TICKS_PER_MIN_W);
                dvs       = p_new;
            end
            cmds_pkg::OP_SYNC_TEMPO: begin
                n_tempo   = quot[TEMPO_W-1:0];
                div_start = 1'b1;
                dvd       = DVD_W'(r_period);
                dvs       = DVS_W'(r_ppqn);
            end
            cmds_pkg::OP_OFF: begin
                n_half = half;
                n_off  = off_adj;
            end
            cmds_pkg::OP_NUDGE: begin
                if (nudge) begin
                    n_start = r_start + adj[TIME_W-1:0];
                end
            end
            cmds_pkg::OP_LOAD_OUT: begin
                if (r_cmd == cmds_pkg::CMD_TICK && r_clocked) begin
                    n_last = r_now;
                end
            end
            default: begin
            end
        endcase

        for (int b = 0; b < MASK_W; b++) begin
            if (tk && (int'(r_ch) == b)) begin
                n_mask[b] = 1'b1;
            end
        end

        if (resync) begin
            n_start = r_now;
            n_phase = ~r_phase;
            for (int c = 0; c < NUM_CLOCKS; c++) begin
                if ((!r_mult[c][MULT_W-1] && r_mult[c] != '0) || !rs_skip) begin
                    n_count[c] = rs_skip ? CNT_W'(1) : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLOCKS; c++) begin
                r_mult[c]  <= MULT_W'(1);
                r_count[c] <= '0;
            end
            r_ppqn    <= '0;
            r_period  <= cmds_pkg::PERIOD_RESET;
            r_start   <= '0;
            r_last    <= '0;
            r_tempo   <= cmds_pkg::TEMPO_RESET;
            r_phase   <= 1'b0;
            r_ch      <= '0;
            r_all_met <= 1'b1;
            r_mask    <= '0;
            r_restart <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_period  <= n_period;
            r_start   <= n_start;
            r_last    <= n_last;
            r_tempo   <= n_tempo;
            r_phase   <= n_phase;
            r_ch      <= n_ch;
            r_all_met <= n_all_met;
            r_mask    <= n_mask;
            r_restart <= n_restart;
            if (i_cfg_we) begin
                for (int c = 0; c < NUM_CLOCKS; c++) begin
                    if (c < cmds_pkg::NUM_MULT_REGS
                        && i_cfg_idx == cmds_pkg::CFG_IDX_W'(c)) begin
                        r_mult[c] <= cmds_pkg::clamp_mult(i_cfg_data);
                    end
                end
                if (i_cfg_idx == cmds_pkg::REG_PPQN) begin
                    r_ppqn <= cmds_pkg::clamp_ppqn(i_cfg_data[PPQN_W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_half <= n_half;
        r_off  <= n_off;
        if (i_ctl.op == cmds_pkg::OP_LATCH) begin
            r_cmd     <= i_cmd;
            r_now     <= i_now;
            r_clocked <= i_clocked;
            r_hard    <= i_hard_reset;
            r_skip    <= i_skip_first;
            r_bpm     <= i_bpm;
        end
        if (i_ctl.op == cmds_pkg::OP_LOAD_OUT) begin
            o_tock_mask       <= r_mask;
            o_beat_restart    <= r_restart;
            o_beat_period_out <= r_period;
            o_tempo_out       <= r_tempo;
            o_beat_phase_out  <= r_phase;
        end
    end

    always_comb begin
        o_st.cmd      = r_cmd;
        o_st.hard     = r_hard;
        o_st.mode     = mode;
        o_st.passed   = passed;
        o_st.last_ch  = r_ch == CH_W'(NUM_CLOCKS - 1);
        o_st.sync_go  = sync_go;
        o_st.sync_ok  = sync_ok;
        o_st.div_busy = div_busy;
    end

endmodule

### sv/cmds_ctrl.sv
// ----------------------------------------------------------------------------
// cmds_ctrl
// Sequencer: walks one item through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module cmds_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    input  cmds_pkg::t_dp_status  i_st,
    output cmds_pkg::t_ctrl_cmd   o_ctl
);
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_BPM_WAIT = 5'd2;
    localparam logic [4:0] S_BPM_WR   = 5'd3;
    localparam logic [4:0] S_CH_EVAL  = 5'd4;
    localparam logic [4:0] S_CH_MDIV  = 5'd5;
    localparam logic [4:0] S_CH_MWAIT = 5'd6;
    localparam logic [4:0] S_CH_MFIN  = 5'd7;
    localparam logic [4:0] S_CH_DWAIT = 5'd8;
    localparam logic [4:0] S_CH_DFIN  = 5'd9;
    localparam logic [4:0] S_CH_NEXT  = 5'd10;
    localparam logic [4:0] S_RESTART  = 5'd11;
    localparam logic [4:0] S_SYNC_MUL = 5'd12;
    localparam logic [4:0] S_SYNC_CHK = 5'd13;
    localparam logic [4:0] S_T_WAIT   = 5'd14;
    localparam logic [4:0] S_T_WR     = 5'd15;
    localparam logic [4:0] S_P_WAIT   = 5'd16;
    localparam logic [4:0] S_OFF      = 5'd17;
    localparam logic [4:0] S_NUDGE    = 5'd18;
    localparam logic [4:0] S_DONE     = 5'd19;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_ctl.op    = cmds_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.op = cmds_pkg::OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_st.cmd)
                    cmds_pkg::CMD_TICK: begin
                        if (i_st.hard) begin
                            o_ctl.op = cmds_pkg::OP_RESYNC_IN;
                        end
                        n_state = S_CH_EVAL;
                    end
                    cmds_pkg::CMD_TEMPO: begin
                        o_ctl.op = cmds_pkg::OP_BPM_DIV;
                        n_state  = S_BPM_WAIT;
                    end
                    cmds_pkg::CMD_RESYNC: begin
                        o_ctl.op = cmds_pkg::OP_RESYNC_IN;
                        n_state  = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_BPM_WAIT: if (!i_st.div_busy) n_state = S_BPM_WR;
            S_BPM_WR: begin
                o_ctl.op = cmds_pkg::OP_BPM_WR;
                n_state  = S_DONE;
            end
            S_CH_EVAL: begin
                o_ctl.op = cmds_pkg::OP_CH_EVAL;
                if (i_st.mode == cmds_pkg::MODE_MUL) begin
                    n_state = S_CH_MDIV;
                end else if (i_st.mode == cmds_pkg::MODE_DIV && i_st.passed) begin
                    n_state = S_CH_DWAIT;
                end else begin
                    n_state = S_CH_NEXT;
                end
            end
            S_CH_MDIV: begin
                o_ctl.op = cmds_pkg::OP_CH_MDIV;
                n_state  = S_CH_MWAIT;
            end
            S_CH_MWAIT: if (!i_st.div_busy) n_state = S_CH_MFIN;
            S_CH_MFIN: begin
                o_ctl.op = cmds_pkg::OP_CH_MFIN;
                n_state  = S_CH_NEXT;
            end
            S_CH_DWAIT: if (!i_st.div_busy) n_state = S_CH_DFIN;
            S_CH_DFIN: begin
                o_ctl.op = cmds_pkg::OP_CH_DFIN;
                n_state  = S_CH_NEXT;
            end
            S_CH_NEXT: begin
                if (i_st.last_ch) begin
                    n_state = S_RESTART;
                end else begin
                    o_ctl.op = cmds_pkg::OP_CH_NEXT;
                    n_state  = S_CH_EVAL;
                end
            end
            S_RESTART: begin
                o_ctl.op = cmds_pkg::OP_RESTART;
                n_state  = S_SYNC_MUL;
            end
            S_SYNC_MUL: begin
                if (i_st.sync_go) begin
                    o_ctl.op = cmds_pkg::OP_SYNC_MUL;
                    n_state  = S_SYNC_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SYNC_CHK: begin
                if (i_st.sync_ok) begin
                    o_ctl.op = cmds_pkg::OP_SYNC_PER;
                    n_state  = S_T_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_T_WAIT: if (!i_st.div_busy) n_state = S_T_WR;
            S_T_WR: begin
                o_ctl.op = cmds_pkg::OP_SYNC_TEMPO;
                n_state  = S_P_WAIT;
            end
            S_P_WAIT: if (!i_st.div_busy) n_state = S_OFF;
            S_OFF: begin
                o_ctl.op = cmds_pkg::OP_OFF;
                n_state  = S_NUDGE;
            end
            S_NUDGE: begin
                o_ctl.op = cmds_pkg::OP_NUDGE;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_ctl.op    = cmds_pkg::OP_LOAD_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_out_valid;

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside done state");

    a_mfin_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CH_MFIN |-> !i_st.div_busy)
        else $error("quotient used while divider busy");

    a_mwait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CH_MWAIT && $past(r_state) == S_CH_MDIV) |-> i_st.div_busy)
        else $error("divider did not start");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_state == S_DECODE)
        else $error("accepted transfer not decoded");

endmodule

### sv/clock_multiplier_divider_sync.sv
// ----------------------------------------------------------------------------
// clock_multiplier_divider_sync
// Tick-driven master clock with multiply/divide channels and external sync.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one command per transfer: a tick
//   step, a tempo set from BPM, or a beat resync. Output channel
//   (o_valid/i_ready) returns exactly one result per command.
//   Config port: i_cfg_we/i_cfg_idx/i_cfg_data, write only while idle;
//   index 0..3 channel multipliers, index 4 external clock PPQN.
//   Work: a tempo command divides once, a resync not at all. A tick
//   divides once per multiplying or passing dividing channel, and twice
//   more when an external pulse updates the period. All divisions go
//   through one shared divider that produces one quotient bit per cycle.
//   One item is processed at a time; the next item is accepted while a
//   finished result waits in the output register.
//   Reset: 120 BPM, beat start 0, counts cleared, all multipliers 1, PPQN 0.
//   A stalled receiver holds the result; processing of the next item stops
//   at its end until the output register frees up.
// ----------------------------------------------------------------------------
module clock_multiplier_divider_sync #(
    parameter int NUM_CLOCKS = 4,
    parameter int TEMPO_MIN  = 1,
    parameter int TEMPO_MAX  = 300
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [cmds_pkg::CMD_W-1:0]      i_cmd,
    input  logic [cmds_pkg::TIME_W-1:0]     i_now,
    input  logic                            i_clocked,
    input  logic                            i_hard_reset,
    input  logic                            i_skip_first,
    input  logic [cmds_pkg::BPM_W-1:0]      i_bpm,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cmds_pkg::MASK_W-1:0]     o_tock_mask,
    output logic                            o_beat_restart,
    output logic [cmds_pkg::PERIOD_W-1:0]   o_beat_period_out,
    output logic [cmds_pkg::TEMPO_W-1:0]    o_tempo_out,
    output logic                            o_beat_phase_out,
    input  logic                            i_cfg_we,
    input  logic [cmds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cmds_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    cmds_pkg::t_ctrl_cmd  ctl;
    cmds_pkg::t_dp_status st;

    cmds_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_st    (st),
        .o_ctl   (ctl)
    );

    cmds_dp #(
        .NUM_CLOCKS (NUM_CLOCKS),
        .TEMPO_MIN  (TEMPO_MIN),
        .TEMPO_MAX  (TEMPO_MAX)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_st              (st),
        .i_cmd             (i_cmd),
        .i_now             (i_now),
        .i_clocked         (i_clocked),
        .i_hard_reset      (i_hard_reset),
        .i_skip_first      (i_skip_first),
        .i_bpm             (i_bpm),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_tock_mask       (o_tock_mask),
        .o_beat_restart    (o_beat_restart),
        .o_beat_period_out (o_beat_period_out),
        .o_tempo_out       (o_tempo_out),
        .o_beat_phase_out  (o_beat_phase_out)
    );

endmodule
